// File: hdl/soil_watering_pump_controller_assert.svh
// assertion macros used by the rtl
`ifndef SOIL_WATERING_PUMP_CONTROLLER_ASSERT_SVH
`define SOIL_WATERING_PUMP_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS

// clocked check, off while reset is asserted
`define SWPC_ASSERT(lbl, ck, rstn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) prop) else $error(msg);

// clocked check that also holds during reset
`define SWPC_ASSERT_ALWAYS(lbl, ck, prop, msg) \
	lbl: assert property (@(posedge ck) prop) else $error(msg);

`else

`define SWPC_ASSERT(lbl, ck, rstn, prop, msg)

`define SWPC_ASSERT_ALWAYS(lbl, ck, prop, msg)

`endif

`endif

// File: hdl/swpc_pkg.sv
package swpc_pkg;

	localparam int PCT_W        = 7;
	localparam int CFG_TIME_W   = 24;
	localparam int DATA_W       = 32;
	localparam int ADDR_W       = 5;
	localparam int REG_IDX_W    = 3;
	localparam int TIME_BITS_DEF = 24;

	// request codes
	localparam logic REQ_TICK   = 1'b0;
	localparam logic REQ_MANUAL = 1'b1;

	// led codes
	localparam logic [1:0] LED_IDLE      = 2'd0;
	localparam logic [1:0] LED_PUMPING   = 2'd1;
	localparam logic [1:0] LED_LOW_ALERT = 2'd2;
	localparam logic [1:0] LED_FAULT     = 2'd3;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_AUTO_MODE      = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_LOW_THRESHOLD  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_HIGH_THRESHOLD = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_MAX_PUMP       = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_CHECK_INTERVAL = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_MIN_REST       = 3'd5;

	// register reset values
	localparam logic                  RST_AUTO_MODE      = 1'b1;
	localparam logic [PCT_W-1:0]      RST_LOW_THRESHOLD  = 7'd30;
	localparam logic [PCT_W-1:0]      RST_HIGH_THRESHOLD = 7'd70;
	localparam logic [CFG_TIME_W-1:0] RST_MAX_PUMP       = 24'd300;
	localparam logic [CFG_TIME_W-1:0] RST_CHECK_INTERVAL = 24'd5;
	localparam logic [CFG_TIME_W-1:0] RST_MIN_REST       = 24'd3600;

	typedef struct packed {
		logic             req_type;
		logic [PCT_W-1:0] moisture_percent;
		logic             fault_flag;
	} in_item_t;

	typedef struct packed {
		logic       pump_running;
		logic [1:0] led_code;
	} out_item_t;

	typedef struct packed {
		logic                  auto_mode;
		logic [PCT_W-1:0]      low_moisture_threshold;
		logic [PCT_W-1:0]      high_moisture_threshold;
		logic [CFG_TIME_W-1:0] max_pump_seconds;
		logic [CFG_TIME_W-1:0] check_interval_seconds;
		logic [CFG_TIME_W-1:0] min_rest_seconds;
	} cfg_t;

endpackage

// File: hdl/soil_watering_pump_controller.sv
// Soil watering pump controller. Each input transaction is a seconds tick or a manual
// start request, carrying the moisture reading and a fault flag; each one yields exactly
// one result transaction with the pump drive and LED code as they stand after it. A new
// transaction is taken every clock cycle while the input is not stalled: the whole state
// update (three saturating elapsed-second counters, threshold and timer compares, pump and
// LED decision) is one level of logic feeding the state registers. The result is
// registered in the output register, or in a skid register while an earlier one waits, so
// the input stays ready then; only a second unclaimed result stalls the input.
// Registers sit on an APB-style port at byte addresses 0x00 to 0x14 (auto mode, low and
// high moisture thresholds, max pump seconds, check interval, min rest seconds); change
// them only while no transaction is in flight. Counters are TIME_BITS wide and a limit
// beyond their all-ones value is never reached.
`include "soil_watering_pump_controller_assert.svh"

module soil_watering_pump_controller #(
	parameter int TIME_BITS = swpc_pkg::TIME_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// input channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  swpc_pkg::in_item_t          in_data,
	// result channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output swpc_pkg::out_item_t         out_data,
	// configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [swpc_pkg::ADDR_W-1:0] paddr,
	input  logic [swpc_pkg::DATA_W-1:0] pwdata,
	output logic [swpc_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);

	// compare width covers both the counters and the 24-bit limits
	localparam int CMP_W = (TIME_BITS > swpc_pkg::CFG_TIME_W) ? TIME_BITS
	                                                          : swpc_pkg::CFG_TIME_W;

	swpc_pkg::cfg_t      cfg;

	// controller state
	logic                 pump_on_q;
	logic [1:0]           led_q;
	logic [TIME_BITS-1:0] chk_q;
	logic [TIME_BITS-1:0] start_q;
	logic [TIME_BITS-1:0] stop_q;

	// next state
	logic                 pump_n;
	logic [1:0]           led_n;
	logic [TIME_BITS-1:0] chk_n;
	logic [TIME_BITS-1:0] start_n;
	logic [TIME_BITS-1:0] stop_n;

	// counters after one second has passed
	logic [TIME_BITS-1:0] chk_inc;
	logic [TIME_BITS-1:0] start_inc;
	logic [TIME_BITS-1:0] stop_inc;

	logic                 check_due;
	logic                 rest_done;
	logic                 run_expired;
	logic                 soil_dry;
	logic                 soil_wet;

	// output register and skid stage
	logic                 out_valid_q;
	swpc_pkg::out_item_t  out_q;
	logic                 skid_valid_q;
	swpc_pkg::out_item_t  skid_q;

	logic                 in_fire;
	logic                 out_pop;
	swpc_pkg::out_item_t  result;

	// register file
	swpc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign pready = 1'b1;

	// handshakes: input stalls only when both result slots are full
	assign in_ready  = ~skid_valid_q;
	assign in_fire   = in_valid & in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_pop   = out_valid_q & out_ready;

	// saturating increments and the compares of a check
	always_comb begin
		chk_inc   = (&chk_q)   ? chk_q   : chk_q   + TIME_BITS'(1);
		start_inc = (&start_q) ? start_q : start_q + TIME_BITS'(1);
		stop_inc  = (&stop_q)  ? stop_q  : stop_q  + TIME_BITS'(1);

		check_due   = CMP_W'(chk_inc)   >= CMP_W'(cfg.check_interval_seconds);
		rest_done   = CMP_W'(stop_inc)  >= CMP_W'(cfg.min_rest_seconds);
		run_expired = CMP_W'(start_inc) >= CMP_W'(cfg.max_pump_seconds);
		soil_dry    = in_data.moisture_percent <  cfg.low_moisture_threshold;
		soil_wet    = in_data.moisture_percent >= cfg.high_moisture_threshold;
	end

	// pump decision and led update
	always_comb begin
		pump_n  = pump_on_q;
		led_n   = led_q;
		chk_n   = chk_q;
		start_n = start_q;
		stop_n  = stop_q;

		if (in_data.req_type == swpc_pkg::REQ_MANUAL) begin
			// manual start: time stands still, mode and sensors are ignored
			if (!pump_on_q) begin
				pump_n  = 1'b1;
				start_n = '0;
			end
		end else begin
			// one second has passed
			chk_n   = chk_inc;
			start_n = start_inc;
			stop_n  = stop_inc;

			if (cfg.auto_mode) begin
				if (check_due) begin
					chk_n = '0;
					if (!pump_on_q) begin
						if (soil_dry && rest_done && !in_data.fault_flag) begin
							pump_n  = 1'b1;
							start_n = '0;
						end
					end else if (soil_wet || run_expired || in_data.fault_flag) begin
						pump_n = 1'b0;
						stop_n = '0;
					end
				end

				// led follows the pump as it stands after the check
				if (in_data.fault_flag)
					led_n = swpc_pkg::LED_FAULT;
				else if (pump_n)
					led_n = swpc_pkg::LED_PUMPING;
				else if (soil_dry)
					led_n = swpc_pkg::LED_LOW_ALERT;
				else
					led_n = swpc_pkg::LED_IDLE;
			end
		end

		result.pump_running = pump_n;
		result.led_code     = led_n;
	end

	// state registers, counters come out of reset saturated so the first tick checks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pump_on_q <= 1'b0;
			led_q     <= swpc_pkg::LED_IDLE;
			chk_q     <= '1;
			start_q   <= '1;
			stop_q    <= '1;
		end else if (in_fire) begin
			pump_on_q <= pump_n;
			led_q     <= led_n;
			chk_q     <= chk_n;
			start_q   <= start_n;
			stop_q    <= stop_n;
		end
	end

	// result slot valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			// input is stalled here, the skid result moves up when taken
			if (out_pop)
				skid_valid_q <= 1'b0;
		end else if (in_fire) begin
			if (out_valid_q && !out_ready)
				skid_valid_q <= 1'b1;
			else
				out_valid_q <= 1'b1;
		end else if (out_pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// result slot payloads
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_pop)
				out_q <= skid_q;
		end else if (in_fire) begin
			if (out_valid_q && !out_ready)
				skid_q <= result;
			else
				out_q <= result;
		end
	end

	// the skid slot is only ever filled behind a waiting output
	`SWPC_ASSERT(a_skid_behind_out, clk, arst_n, skid_valid_q |-> out_valid_q,
		"skid slot holds a transaction while the output slot is empty")

	// a manual request always leaves the pump running
	`SWPC_ASSERT(a_manual_runs_pump, clk, arst_n,
		in_fire && in_data.req_type == swpc_pkg::REQ_MANUAL |=> pump_on_q,
		"pump not running after a manual start request")

	// every start clears the run timer
	`SWPC_ASSERT(a_start_clears_timer, clk, arst_n,
		$rose(pump_on_q) |-> start_q == '0,
		"pump started without clearing the run timer")

	// the watering led is only shown while the pump runs
	`SWPC_ASSERT_ALWAYS(a_led_matches_pump, clk,
		led_q == swpc_pkg::LED_PUMPING |-> pump_on_q,
		"watering led shown with the pump off")

endmodule

// File: hdl/swpc_regs.sv
module swpc_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [swpc_pkg::ADDR_W-1:0]   paddr,
	input  logic [swpc_pkg::DATA_W-1:0]   pwdata,
	output logic [swpc_pkg::DATA_W-1:0]   prdata,
	output swpc_pkg::cfg_t                cfg
);

	swpc_pkg::cfg_t                      cfg_q;
	logic [swpc_pkg::REG_IDX_W-1:0]      idx;
	logic                                wr_en;

	assign idx   = paddr[swpc_pkg::ADDR_W-1:2];
	assign wr_en = psel & penable & pwrite;
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.auto_mode               <= swpc_pkg::RST_AUTO_MODE;
			cfg_q.low_moisture_threshold  <= swpc_pkg::RST_LOW_THRESHOLD;
			cfg_q.high_moisture_threshold <= swpc_pkg::RST_HIGH_THRESHOLD;
			cfg_q.max_pump_seconds        <= swpc_pkg::RST_MAX_PUMP;
			cfg_q.check_interval_seconds  <= swpc_pkg::RST_CHECK_INTERVAL;
			cfg_q.min_rest_seconds        <= swpc_pkg::RST_MIN_REST;
		end else if (wr_en) begin
			unique case (idx)
				swpc_pkg::REG_AUTO_MODE:      cfg_q.auto_mode <= pwdata[0];
				swpc_pkg::REG_LOW_THRESHOLD:
					cfg_q.low_moisture_threshold <= pwdata[swpc_pkg::PCT_W-1:0];
				swpc_pkg::REG_HIGH_THRESHOLD:
					cfg_q.high_moisture_threshold <= pwdata[swpc_pkg::PCT_W-1:0];
				swpc_pkg::REG_MAX_PUMP:
					cfg_q.max_pump_seconds <= pwdata[swpc_pkg::CFG_TIME_W-1:0];
				swpc_pkg::REG_CHECK_INTERVAL:
					cfg_q.check_interval_seconds <= pwdata[swpc_pkg::CFG_TIME_W-1:0];
				swpc_pkg::REG_MIN_REST:
					cfg_q.min_rest_seconds <= pwdata[swpc_pkg::CFG_TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// read back, unused addresses read zero
	always_comb begin
		prdata = '0;
		unique case (idx)
			swpc_pkg::REG_AUTO_MODE:      prdata = swpc_pkg::DATA_W'(cfg_q.auto_mode);
			swpc_pkg::REG_LOW_THRESHOLD:
				prdata = swpc_pkg::DATA_W'(cfg_q.low_moisture_threshold);
			swpc_pkg::REG_HIGH_THRESHOLD:
				prdata = swpc_pkg::DATA_W'(cfg_q.high_moisture_threshold);
			swpc_pkg::REG_MAX_PUMP:
				prdata = swpc_pkg::DATA_W'(cfg_q.max_pump_seconds);
			swpc_pkg::REG_CHECK_INTERVAL:
				prdata = swpc_pkg::DATA_W'(cfg_q.check_interval_seconds);
			swpc_pkg::REG_MIN_REST:
				prdata = swpc_pkg::DATA_W'(cfg_q.min_rest_seconds);
			default: prdata = '0;
		endcase
	end

endmodule
